>>> rtl/enm_pkg.sv
// Package for the epsilon neighbor mask core: sizes, codes, payload types, FSM states.
// No dependencies; every other file imports it.
package enm_pkg;

   localparam int MAX_POINTS    = 128;
   localparam int FEATURE_COUNT = 16;
   localparam int MASK_WIDTH    = 16;
   localparam int FEAT_W        = 16;
   localparam int BLOCKS        = MAX_POINTS / MASK_WIDTH;
   localparam int ROWS          = BLOCKS * FEATURE_COUNT;
   localparam int FIDX_W        = $clog2(FEATURE_COUNT);
   localparam int LANE_IDX_W    = $clog2(MASK_WIDTH);
   localparam int BLK_W         = $clog2(BLOCKS);
   localparam int ROW_W         = $clog2(ROWS);
   localparam int ROW_BITS      = MASK_WIDTH * FEAT_W;
   localparam int SQ_W          = 2 * FEAT_W;
   localparam int ACC_W         = SQ_W + FIDX_W;
   localparam int RADIUS_W      = 38;
   localparam int COUNT_W       = 8;
   localparam int CSR_IDX_W     = 2;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 38'd189399;
   localparam logic [COUNT_W-1:0]  COUNT_RESET  = 8'd112;

   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT  = 2'd1;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   typedef struct packed {
      logic               action;
      logic [6:0]         point_index;
      logic [3:0]         feature_index;
      logic signed [15:0] feature_value;
      logic [2:0]         block_index;
   } req_type;

   typedef struct packed {
      logic [15:0] neighbor_mask;
      logic [6:0]  query_point;
      logic [2:0]  query_block;
   } rsp_type;

   typedef struct packed {
      logic clear;     // start of a query: zero accumulators
      logic rd_valid;  // store read data valid this cycle
      logic rd_last;   // that data is the last feature
   } lane_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_RESULT
   } state_type;

endpackage

>>> rtl/enm_store.sv
// Point store: one row per (block, feature), one 16-bit lane per point of the block.
// Lane write, two registered read ports. Depends on enm_pkg.
module enm_store (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [enm_pkg::ROW_W-1:0] wr_row,
   input  logic [enm_pkg::LANE_IDX_W-1:0] wr_lane,
   input  logic [enm_pkg::FEAT_W-1:0] wr_data,
   input  logic [enm_pkg::ROW_W-1:0] rd_row_a,
   input  logic [enm_pkg::ROW_W-1:0] rd_row_b,
   output logic [enm_pkg::ROW_BITS-1:0] rd_data_a,
   output logic [enm_pkg::ROW_BITS-1:0] rd_data_b
);
   import enm_pkg::*;

   logic [ROW_BITS-1:0] mem [ROWS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_row][wr_lane*FEAT_W +: FEAT_W] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_a <= mem[rd_row_a];
      rd_data_b <= mem[rd_row_b];
   end

endmodule

>>> rtl/enm_lanes.sv
// Sixteen distance lanes: absolute difference, square (registered), accumulate.
// Depends on enm_pkg.
module enm_lanes (
   input  logic                           clock,
   input  logic                           reset,
   input  enm_pkg::lane_ctl_type          ctl,
   input  logic [enm_pkg::ROW_BITS-1:0]   blk_row,
   input  logic [enm_pkg::ROW_BITS-1:0]   qry_row,
   input  logic [enm_pkg::LANE_IDX_W-1:0] qry_lane,
   output logic [enm_pkg::ACC_W-1:0]      acc [enm_pkg::MASK_WIDTH],
   output logic                           done
);
   import enm_pkg::*;

   logic signed [FEAT_W-1:0] q_feat;
   logic [FEAT_W-1:0]        abs_d [MASK_WIDTH];
   logic [SQ_W-1:0]          sq_ff [MASK_WIDTH];
   logic [ACC_W-1:0]         acc_ff [MASK_WIDTH];
   logic                     sq_valid_ff, sq_last_ff, done_ff;

   assign q_feat = qry_row[qry_lane*FEAT_W +: FEAT_W];

   always_comb begin
      logic signed [FEAT_W:0] d;
      for (int k = 0; k < MASK_WIDTH; k++) begin
         d = {blk_row[k*FEAT_W+FEAT_W-1], blk_row[k*FEAT_W +: FEAT_W]}
             - {q_feat[FEAT_W-1], q_feat};
         // |d| <= 65535 fits in the lane width
         abs_d[k] = d[FEAT_W] ? FEAT_W'(-d) : d[FEAT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MASK_WIDTH; k++) begin
         sq_ff[k] <= abs_d[k] * abs_d[k];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MASK_WIDTH; k++) begin
         if (ctl.clear) begin
            acc_ff[k] <= '0;
         end else if (sq_valid_ff) begin
            acc_ff[k] <= acc_ff[k] + ACC_W'(sq_ff[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
         sq_last_ff  <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         sq_valid_ff <= ctl.rd_valid;
         sq_last_ff  <= ctl.rd_valid & ctl.rd_last;
         done_ff     <= sq_valid_ff & sq_last_ff;
      end
   end

   assign acc  = acc_ff;
   assign done = done_ff;

endmodule

>>> rtl/epsilon_neighbor_mask_core.sv
// Top level of the epsilon neighbor mask core: handshakes, config registers,
// query sequencer, result register. Depends on enm_pkg, enm_store, enm_lanes.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | enm_pkg::req_type (load or query)
//   rsp     | out       | rsp_valid/rsp_ready  | enm_pkg::rsp_type (one per query)
//   csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// A load item is written into the store at acceptance.
// A query item makes 16 store reads (one feature row per cycle, shared by the 16 lanes),
// then runs through the square register and the accumulators into the result compare.
// Reset clears control state and sets the config registers to their reset values; the point store is not cleared.
// A waiting result sits in the output register; the engine can take and run
// the next query meanwhile, and holds its result until the register is free.
module epsilon_neighbor_mask_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  enm_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output enm_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [enm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [enm_pkg::RADIUS_W-1:0]       csr_data
);
   import enm_pkg::*;

   // configuration
   logic [RADIUS_W-1:0] radius_ff;
   logic [COUNT_W-1:0]  count_ff;

   // sequencer
   state_type         state_ff, state_in;
   logic [FIDX_W-1:0] feat_ff;
   logic [6:0]        qpoint_ff;
   logic [2:0]        qblock_ff;
   logic              rd_valid_ff, rd_last_ff;

   // result register
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   // FSM outputs
   logic req_take, query_start, issue, rsp_load, last_feat;

   logic [ROW_W-1:0]    wr_row, rd_row_a, rd_row_b;
   logic [ROW_BITS-1:0] blk_row, qry_row;
   logic [ACC_W-1:0]    acc [MASK_WIDTH];
   logic                lanes_done;
   lane_ctl_type        lane_ctl;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
         count_ff  <= COUNT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RADIUS: radius_ff <= csr_data;
            CSR_COUNT:  count_ff  <= csr_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign last_feat = (feat_ff == FIDX_W'(FEATURE_COUNT - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid && req_data.action == ACT_QUERY) state_in = ST_ISSUE;
         ST_ISSUE:  if (last_feat) state_in = ST_DRAIN;
         ST_DRAIN:  if (lanes_done) state_in = ST_RESULT;
         ST_RESULT: if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // FSM outputs
   always_comb begin
      req_ready = 1'b0;
      issue     = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_ISSUE:  issue = 1'b1;
         ST_DRAIN:  ;
         ST_RESULT: rsp_load = !rsp_valid_ff || rsp_ready;
         default:   ;
      endcase
   end

   assign req_take    = req_valid && req_ready;
   assign query_start = req_take && req_data.action == ACT_QUERY;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         feat_ff     <= '0;
         rd_valid_ff <= 1'b0;
         rd_last_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= issue;
         rd_last_ff  <= issue && last_feat;
         if (query_start) begin
            feat_ff <= '0;
         end else if (issue) begin
            feat_ff <= feat_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (query_start) begin
         qpoint_ff <= req_data.point_index;
         qblock_ff <= req_data.block_index;
      end
   end

   // store addressing: row = block * features + feature, lane = point within block
   assign wr_row   = {req_data.point_index[6:LANE_IDX_W], req_data.feature_index};
   assign rd_row_a = {qblock_ff, feat_ff};
   assign rd_row_b = {qpoint_ff[6:LANE_IDX_W], feat_ff};

   enm_store u_store (
      .clock     (clock),
      .wr_en     (req_take && req_data.action == ACT_LOAD),
      .wr_row    (wr_row),
      .wr_lane   (req_data.point_index[LANE_IDX_W-1:0]),
      .wr_data   (req_data.feature_value),
      .rd_row_a  (rd_row_a),
      .rd_row_b  (rd_row_b),
      .rd_data_a (blk_row),
      .rd_data_b (qry_row)
   );

   assign lane_ctl.clear    = query_start;
   assign lane_ctl.rd_valid = rd_valid_ff;
   assign lane_ctl.rd_last  = rd_last_ff;

   enm_lanes u_lanes (
      .clock    (clock),
      .reset    (reset),
      .ctl      (lane_ctl),
      .blk_row  (blk_row),
      .qry_row  (qry_row),
      .qry_lane (qpoint_ff[LANE_IDX_W-1:0]),
      .acc      (acc),
      .done     (lanes_done)
   );

   // compare: point in range, query point in range, distance at or below radius
   always_comb begin
      logic [COUNT_W-1:0] j;
      logic               q_ok;
      q_ok   = {1'b0, qpoint_ff} < count_ff;
      rsp_in = '0;
      rsp_in.query_point = qpoint_ff;
      rsp_in.query_block = qblock_ff;
      for (int k = 0; k < MASK_WIDTH; k++) begin
         j = COUNT_W'({qblock_ff, LANE_IDX_W'(k)});
         rsp_in.neighbor_mask[k] = q_ok && (j < count_ff)
                                   && ({{(RADIUS_W-ACC_W){1'b0}}, acc[k]} <= radius_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> tb/sv/neighbor_mask_checker.sv
// Checker for the epsilon neighbor mask core: watches the req, rsp and csr channels,
// keeps its own copy of the point store and registers, predicts every mask and compares.
// Depends on enm_pkg for sizes, codes and payload types.
`timescale 1ns / 1ps

module neighbor_mask_checker
   import enm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rsp_type              rsp_data,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [RADIUS_W-1:0]  csr_data,
   output int                   mismatches,
   output int                   pending,
   output int                   compared
);

   localparam int PRINT_CAP = 100;

   logic signed [FEAT_W-1:0] feature_store [MAX_POINTS*FEATURE_COUNT];
   logic [RADIUS_W-1:0]      radius_sq;
   logic [COUNT_W-1:0]       active_points;
   rsp_type                  masks_due [$];
   rsp_type                  want;

   initial begin
      mismatches = 0;
      pending    = 0;
      compared   = 0;
   end

   task automatic report_mismatch(input string what);
      if (mismatches < PRINT_CAP)
         $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
   endtask

   // Bit k is set when point 16*blk+k and query point qp are below the count and within the radius.
   function automatic logic [MASK_WIDTH-1:0] neighbors_of(input logic [6:0] qp,
                                                         input logic [2:0] blk);
      logic [MASK_WIDTH-1:0]  mask;
      logic [39:0]            sum_sq;
      logic signed [FEAT_W:0] diff;
      logic [2*FEAT_W+1:0]    sq;
      int                     j;
      mask = '0;
      if (qp < active_points) begin
         for (int k = 0; k < MASK_WIDTH; k++) begin
            j = blk * MASK_WIDTH + k;
            if (j < active_points && j < MAX_POINTS) begin
               sum_sq = '0;
               for (int f = 0; f < FEATURE_COUNT; f++) begin
                  diff = feature_store[qp*FEATURE_COUNT+f] - feature_store[j*FEATURE_COUNT+f];
                  sq     = diff * diff;
                  sum_sq = sum_sq + sq;
               end
               if (sum_sq <= {2'b00, radius_sq})
                  mask[k] = 1'b1;
            end
         end
      end
      return mask;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         radius_sq     = RADIUS_RESET;
         active_points = COUNT_RESET;
         masks_due.delete();
      end else begin
         // a result always belongs to an earlier query, so pop before push
         if (rsp_valid && rsp_ready) begin
            if (masks_due.size() == 0) begin
               report_mismatch($sformatf("unexpected result mask %h point %0d block %0d",
                  rsp_data.neighbor_mask, rsp_data.query_point, rsp_data.query_block));
            end else begin
               want = masks_due.pop_front();
               compared++;
               if (rsp_data.neighbor_mask !== want.neighbor_mask)
                  report_mismatch($sformatf("neighbor_mask %h, expected %h (point %0d block %0d)",
                     rsp_data.neighbor_mask, want.neighbor_mask,
                     want.query_point, want.query_block));
               if (rsp_data.query_point !== want.query_point)
                  report_mismatch($sformatf("query_point %0d, expected %0d",
                     rsp_data.query_point, want.query_point));
               if (rsp_data.query_block !== want.query_block)
                  report_mismatch($sformatf("query_block %0d, expected %0d",
                     rsp_data.query_block, want.query_block));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_RADIUS: radius_sq     = csr_data;
               CSR_COUNT:  active_points = csr_data[COUNT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (req_data.action == ACT_LOAD) begin
               feature_store[req_data.point_index*FEATURE_COUNT + req_data.feature_index] =
                  req_data.feature_value;
            end else begin
               want.neighbor_mask = neighbors_of(req_data.point_index, req_data.block_index);
               want.query_point   = req_data.point_index;
               want.query_block   = req_data.block_index;
               masks_due.push_back(want);
            end
         end
      end
      pending = masks_due.size();
   end

endmodule

>>> tb/sv/epsilon_neighbor_mask_core_test.sv
// Top of the epsilon neighbor mask testbench: clock, reset, stimulus and verdict.
// Depends on enm_pkg, the core RTL and neighbor_mask_checker.
`timescale 1ns / 1ps

module epsilon_neighbor_mask_core_test;
   import enm_pkg::*;

   // Slowest correct run: ~500 items, each with at most the largest send gap, its query
   // work and the largest result stall; the limit is far above.
   localparam int CYCLE_LIMIT    = 1000000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int ITEMS_PER_PASS = 34;
   localparam int PASSES         = 5;
   localparam int CLUSTERS       = 4;
   localparam int JITTER         = 100;    // Q8.8 raw units, puts pairs near the radius
   localparam int FEAT_MAX       = 32767;
   localparam int FEAT_MIN       = -32768;
   // points 0..FILLED_POINTS-1 are fully loaded; the point count never goes past them
   localparam int FILLED_POINTS  = 20;

   localparam logic [RADIUS_W-1:0]  RADIUS_MAX  = '1;
   // 16 features at the widest difference, 16 * 65535^2
   localparam logic [RADIUS_W-1:0]  RADIUS_SPAN = 38'd68717379600;
   // indexes past the two registers: writes there must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [RADIUS_W-1:0]  csr_data  = '0;

   int mismatches;
   int pending;
   int compared;

   int cycles     = 0;
   int loads_sent = 0;
   int queries_sent = 0;
   int reg_writes = 0;
   int calm_req   = 0;
   int calm_rsp   = 0;

   // every point belongs to a cluster; features scatter a little around its center
   int center     [CLUSTERS][FEATURE_COUNT];
   int cluster_of [MAX_POINTS];

   epsilon_neighbor_mask_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   neighbor_mask_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .mismatches (mismatches),
      .pending    (pending),
      .compared   (compared)
   );

   always #2 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Wait before the next item: mostly a random gap, now and then a calm
   // stretch of back-to-back items.
   task automatic draw_gap(inout int calm, output int gap);
      if (calm > 0) begin
         calm--;
         gap = 0;
      end else if ($urandom_range(0, 24) == 0) begin
         calm = $urandom_range(8, 40);
         gap  = 0;
      end else begin
         gap = $urandom_range(0, 14);
      end
   endtask

   // Valid stays high after acceptance; it is lowered only by the next send with
   // a gap, or by settle(), always in the step the item was taken.
   task automatic send_item(input req_type item);
      int gap;
      draw_gap(calm_req, gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      if (item.action == ACT_QUERY)
         queries_sent++;
      else
         loads_sent++;
   endtask

   // Register writes happen only with the core idle; see settle().
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [RADIUS_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      reg_writes++;
   endtask

   // Drain: every expected mask back, then room for a query still in flight.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Don't-care fields get random content.
   function automatic req_type load_item(input int p, input int f, input int v);
      req_type it;
      it.action        = ACT_LOAD;
      it.point_index   = 7'(p);
      it.feature_index = 4'(f);
      it.feature_value = 16'(v);
      it.block_index   = 3'($urandom_range(0, 7));
      return it;
   endfunction

   function automatic req_type query_item(input int p, input int blk);
      req_type it;
      it.action        = ACT_QUERY;
      it.point_index   = 7'(p);
      it.feature_index = 4'($urandom_range(0, 15));
      it.feature_value = 16'($urandom_range(0, 65535));
      it.block_index   = 3'(blk);
      return it;
   endfunction

   function automatic int clustered(input int p, input int f);
      int jit;
      jit = $urandom_range(0, 2 * JITTER);
      return center[cluster_of[p]][f] + jit - JITTER;
   endfunction

   // ~45% loads (mostly on-cluster, some wild values), the rest queries.
   // Points a little past the loaded range and blocks past the count show up too.
   task automatic send_random_item();
      int p;
      int f;
      int v;
      int blk;
      p = $urandom_range(0, FILLED_POINTS + 3);
      f = $urandom_range(0, FEATURE_COUNT - 1);
      if ($urandom_range(0, 99) < 45) begin
         if ($urandom_range(0, 6) == 0)
            v = int'($urandom_range(0, 65535)) + FEAT_MIN;
         else
            v = clustered(p, f);
         send_item(load_item(p, f, v));
      end else begin
         if ($urandom_range(0, 3) == 0)
            blk = $urandom_range(0, 7);
         else
            blk = $urandom_range(0, 1);
         send_item(query_item(p, blk));
      end
   endtask

   // Result side: random stalls of rsp_ready, one draw per result.
   initial begin
      int stall;
      forever begin
         draw_gap(calm_rsp, stall);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   initial begin
      int v;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int c = 0; c < CLUSTERS; c++)
         for (int f = 0; f < FEATURE_COUNT; f++)
            center[c][f] = int'($urandom_range(0, 64000)) - 32000;
      for (int p = 0; p < MAX_POINTS; p++)
         cluster_of[p] = $urandom_range(0, CLUSTERS - 1);

      // Fill the low points; the count stays within them, so no query
      // ever touches an unwritten entry.
      // Points 0 and 1 sit at the two extremes of Q8.8, point 2 at zero.
      settle();
      for (int p = 0; p < FILLED_POINTS; p++) begin
         for (int f = 0; f < FEATURE_COUNT; f++) begin
            if (p == 0)
               v = FEAT_MAX;
            else if (p == 1)
               v = FEAT_MIN;
            else if (p == 2)
               v = 0;
            else
               v = clustered(p, f);
            send_item(load_item(p, f, v));
         end
      end

      // Directed: widest radius, all loaded points - every bit of a full block set;
      // top point and top block lie past the count
      settle();
      write_reg(CSR_RADIUS, RADIUS_MAX);
      write_reg(CSR_COUNT, RADIUS_W'(FILLED_POINTS));
      send_item(query_item(0, 0));
      send_item(query_item(127, 7));
      send_item(query_item(2, 0));

      // radius exactly the extreme-pair distance: at-or-below keeps bit 1
      settle();
      write_reg(CSR_RADIUS, RADIUS_SPAN);
      send_item(query_item(0, 0));
      send_item(query_item(1, 0));

      // one below it: the extreme pair drops out
      settle();
      write_reg(CSR_RADIUS, RADIUS_SPAN - 1'b1);
      send_item(query_item(0, 0));

      // zero radius: only the point itself (and exact copies) remain
      settle();
      write_reg(CSR_RADIUS, '0);
      send_item(query_item(5, 0));
      send_item(query_item(17, 1));

      // smallest count: block point past the count, query point past the count
      settle();
      write_reg(CSR_COUNT, RADIUS_W'(1));
      send_item(query_item(0, 0));
      send_item(query_item(1, 0));
      send_item(query_item(0, 7));

      // writes to the unused indexes must leave both registers alone
      settle();
      write_reg(CSR_SPARE_LO, RADIUS_MAX);
      write_reg(CSR_SPARE_HI, RADIUS_MAX);
      send_item(query_item(0, 0));
      send_item(query_item(3, 0));

      // Random passes, each under its own register setting
      for (int pass = 0; pass < PASSES; pass++) begin
         settle();
         case (pass)
            0: begin
               write_reg(CSR_RADIUS, RADIUS_RESET);
               write_reg(CSR_COUNT, RADIUS_W'(FILLED_POINTS));
            end
            1: begin
               write_reg(CSR_RADIUS, RADIUS_W'($urandom_range(0, 400000)));
               write_reg(CSR_COUNT, RADIUS_W'($urandom_range(1, FILLED_POINTS)));
            end
            2: begin
               write_reg(CSR_RADIUS, '0);
               write_reg(CSR_COUNT, RADIUS_W'(FILLED_POINTS));
            end
            3: begin
               write_reg(CSR_RADIUS, RADIUS_MAX);
               write_reg(CSR_COUNT, RADIUS_W'($urandom_range(1, FILLED_POINTS)));
            end
            default: begin
               write_reg(CSR_RADIUS, RADIUS_W'({$urandom(), $urandom()}));
               write_reg(CSR_COUNT, RADIUS_W'($urandom_range(1, FILLED_POINTS)));
            end
         endcase
         repeat (ITEMS_PER_PASS) send_random_item();
      end

      settle();
      $display("covered %0d feature loads, %0d queries, %0d register writes",
               loads_sent, queries_sent, reg_writes);
      $display("%0d neighbor masks compared, %0d mismatches", compared, mismatches);
      if (mismatches == 0 && pending == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
